/* rtl/tts_pkg.sv */
package tts_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;
   localparam int INT_BITS  = WORD_BITS - FRAC_BITS;
   localparam int DIFF_W    = WORD_BITS + 1;
   localparam int PROD_W    = 2 * DIFF_W;
   localparam int ACC_W     = PROD_W + 1;
   localparam int MCNT_W    = $clog2(DIFF_W);
   localparam int DCNT_W    = $clog2(WORD_BITS);

   typedef struct packed {
      logic signed [WORD_BITS-1:0] pos_x;
      logic signed [WORD_BITS-1:0] pos_y;
      logic signed [WORD_BITS-1:0] pos_z;
      logic signed [WORD_BITS-1:0] tex_u;
      logic signed [WORD_BITS-1:0] tex_v;
      logic                        face_start;
   } req_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] tangent_x;
      logic signed [WORD_BITS-1:0] tangent_y;
      logic signed [WORD_BITS-1:0] tangent_z;
      logic                        degenerate;
      logic                        saturated;
   } rsp_type;

endpackage

/* rtl/triangle_tangent_stream.sv */
// From an accepted vertex to its tangent the block runs eight bit-serial 33x33 products
// and three bit-serial divisions. A zero UV determinant ends after the first two products.
// One triangle is in work at a time.
// Synchronous active-high reset empties the held vertices; no result is pending after it.
module triangle_tangent_stream (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tts_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tts_pkg::rsp_type rsp_data
);
   import tts_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_OUT} state_type;

   state_type                   state_ff;
   logic signed [WORD_BITS-1:0] old_pos_ff [3];
   logic signed [WORD_BITS-1:0] mid_pos_ff [3];
   logic signed [WORD_BITS-1:0] old_tex_ff [2];
   logic signed [WORD_BITS-1:0] mid_tex_ff [2];
   logic [1:0]                  count_ff;
   logic [1:0]                  count_in;
   logic signed [WORD_BITS-1:0] new_pos [3];
   logic signed [WORD_BITS-1:0] new_tex [2];
   logic signed [DIFF_W-1:0]    e1_ff [3];
   logic signed [DIFF_W-1:0]    e2_ff [3];
   logic signed [DIFF_W-1:0]    du1_ff, dv1_ff, du2_ff, dv2_ff;
   logic [2:0]                  k_ff;
   logic [1:0]                  comp_ff;
   logic signed [ACC_W-1:0]     acc_ff;
   logic signed [ACC_W-1:0]     det_ff;
   logic signed [ACC_W-1:0]     num_ff;
   logic signed [WORD_BITS-1:0] tan_ff [3];
   logic                        deg_ff;
   logic                        sat_ff;
   logic                        mul_start_ff;
   logic                        div_start_ff;
   logic signed [DIFF_W-1:0]    op_a, op_b;
   logic                        mul_done;
   logic signed [PROD_W-1:0]    prod;
   logic signed [ACC_W-1:0]     prod_ext;
   logic signed [ACC_W-1:0]     acc_sub;
   logic                        div_done;
   logic signed [WORD_BITS-1:0] quo;
   logic                        clip;
   logic                        accept;

   assign new_pos[0] = req_data.pos_x;
   assign new_pos[1] = req_data.pos_y;
   assign new_pos[2] = req_data.pos_z;
   assign new_tex[0] = req_data.tex_u;
   assign new_tex[1] = req_data.tex_v;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign count_in  = req_data.face_start ? 2'd0 : count_ff;

   // det = du1*dv2 - du2*dv1, then num[i] = dv2*e1[i] - dv1*e2[i]
   always_comb begin
      if (!k_ff[0]) begin
         op_a = (k_ff == 3'd0) ? du1_ff : dv2_ff;
         op_b = (k_ff == 3'd0) ? dv2_ff : e1_ff[comp_ff];
      end else begin
         op_a = (k_ff == 3'd1) ? du2_ff : dv1_ff;
         op_b = (k_ff == 3'd1) ? dv1_ff : e2_ff[comp_ff];
      end
   end

   tts_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start_ff),
      .a     (op_a),
      .b     (op_b),
      .done  (mul_done),
      .prod  (prod)
   );

   assign prod_ext = {prod[PROD_W-1], prod};
   assign acc_sub  = acc_ff - prod_ext;

   tts_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start_ff),
      .num   (num_ff),
      .den   (det_ff),
      .done  (div_done),
      .quo   (quo),
      .clip  (clip)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= 2'd0;
         mul_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            old_pos_ff[i] <= '0;
            mid_pos_ff[i] <= '0;
         end
         for (int i = 0; i < 2; i++) begin
            old_tex_ff[i] <= '0;
            mid_tex_ff[i] <= '0;
         end
      end else begin
         mul_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  for (int i = 0; i < 3; i++) begin
                     e1_ff[i] <= {mid_pos_ff[i][WORD_BITS-1], mid_pos_ff[i]}
                               - {old_pos_ff[i][WORD_BITS-1], old_pos_ff[i]};
                     e2_ff[i] <= {new_pos[i][WORD_BITS-1], new_pos[i]}
                               - {old_pos_ff[i][WORD_BITS-1], old_pos_ff[i]};
                     old_pos_ff[i] <= mid_pos_ff[i];
                     mid_pos_ff[i] <= new_pos[i];
                  end
                  du1_ff <= {mid_tex_ff[0][WORD_BITS-1], mid_tex_ff[0]}
                          - {old_tex_ff[0][WORD_BITS-1], old_tex_ff[0]};
                  dv1_ff <= {mid_tex_ff[1][WORD_BITS-1], mid_tex_ff[1]}
                          - {old_tex_ff[1][WORD_BITS-1], old_tex_ff[1]};
                  du2_ff <= {new_tex[0][WORD_BITS-1], new_tex[0]}
                          - {old_tex_ff[0][WORD_BITS-1], old_tex_ff[0]};
                  dv2_ff <= {new_tex[1][WORD_BITS-1], new_tex[1]}
                          - {old_tex_ff[1][WORD_BITS-1], old_tex_ff[1]};
                  for (int i = 0; i < 2; i++) begin
                     old_tex_ff[i] <= mid_tex_ff[i];
                     mid_tex_ff[i] <= new_tex[i];
                  end
                  k_ff    <= 3'd0;
                  comp_ff <= 2'd0;
                  deg_ff  <= 1'b0;
                  sat_ff  <= 1'b0;
                  if (count_in == 2'd2) begin
                     count_ff     <= count_in;
                     mul_start_ff <= 1'b1;
                     state_ff     <= ST_MUL;
                  end else begin
                     count_ff <= count_in + 2'd1;
                  end
               end
            end
            ST_MUL: begin
               if (mul_done) begin
                  if (!k_ff[0]) begin
                     acc_ff       <= prod_ext;
                     k_ff         <= k_ff + 3'd1;
                     mul_start_ff <= 1'b1;
                  end else if (k_ff == 3'd1) begin
                     det_ff <= acc_sub;
                     if (acc_sub == '0) begin
                        // degenerate UV: zero tangent
                        deg_ff <= 1'b1;
                        for (int i = 0; i < 3; i++) tan_ff[i] <= '0;
                        state_ff <= ST_OUT;
                     end else begin
                        k_ff         <= 3'd2;
                        mul_start_ff <= 1'b1;
                     end
                  end else begin
                     num_ff       <= acc_sub;
                     div_start_ff <= 1'b1;
                     state_ff     <= ST_DIV;
                  end
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  tan_ff[comp_ff] <= quo;
                  sat_ff          <= sat_ff | clip;
                  if (comp_ff == 2'd2) begin
                     state_ff <= ST_OUT;
                  end else begin
                     comp_ff      <= comp_ff + 2'd1;
                     k_ff         <= k_ff + 3'd1;
                     mul_start_ff <= 1'b1;
                     state_ff     <= ST_MUL;
                  end
               end
            end
            ST_OUT: begin
               if (rsp_ready) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid           = (state_ff == ST_OUT);
   assign rsp_data.tangent_x  = tan_ff[0];
   assign rsp_data.tangent_y  = tan_ff[1];
   assign rsp_data.tangent_z  = tan_ff[2];
   assign rsp_data.degenerate = deg_ff;
   assign rsp_data.saturated  = sat_ff;

endmodule

/* rtl/tts_mul.sv */
module tts_mul (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [tts_pkg::DIFF_W-1:0]  a,
   input  logic signed [tts_pkg::DIFF_W-1:0]  b,
   output logic                               done,
   output logic signed [tts_pkg::PROD_W-1:0]  prod
);
   import tts_pkg::*;

   logic              busy_ff;
   logic              done_ff;
   logic              neg_ff;
   logic [MCNT_W-1:0] cnt_ff;
   logic [DIFF_W-1:0] mag_ff;
   logic [PROD_W-1:0] p_ff;
   logic [PROD_W-1:0] p_in;
   logic [DIFF_W:0]   sum;
   logic [DIFF_W-1:0] mag_a;
   logic [DIFF_W-1:0] mag_b;

   assign mag_a = a[DIFF_W-1] ? (~a + 1'b1) : a;
   assign mag_b = b[DIFF_W-1] ? (~b + 1'b1) : b;

   // one multiplier bit per cycle: add into the upper half, shift right
   assign sum  = {1'b0, p_ff[PROD_W-1:DIFF_W]} + (p_ff[0] ? {1'b0, mag_ff} : '0);
   assign p_in = {sum, p_ff[DIFF_W-1:1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            mag_ff  <= mag_a;
            p_ff    <= {{DIFF_W{1'b0}}, mag_b};
            neg_ff  <= a[DIFF_W-1] ^ b[DIFF_W-1];
         end else if (busy_ff) begin
            p_ff   <= p_in;
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == MCNT_W'(DIFF_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign prod = neg_ff ? (~p_ff + 1'b1) : p_ff;

endmodule

/* rtl/tts_div.sv */
module tts_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [tts_pkg::ACC_W-1:0]     num,
   input  logic signed [tts_pkg::ACC_W-1:0]     den,
   output logic                                 done,
   output logic signed [tts_pkg::WORD_BITS-1:0] quo,
   output logic                                 clip
);
   import tts_pkg::*;

   logic                 busy_ff;
   logic                 done_ff;
   logic                 neg_ff;
   logic                 over_ff;
   logic [DCNT_W-1:0]    cnt_ff;
   logic [ACC_W-1:0]     md_ff;
   logic [ACC_W-1:0]     rem_ff;
   logic [ACC_W-1:0]     rem_in;
   logic [WORD_BITS-1:0] bits_ff;
   logic [WORD_BITS-1:0] q_ff;
   logic [ACC_W-1:0]     mn;
   logic [ACC_W-1:0]     md;
   logic [ACC_W-1:0]     top;
   logic [ACC_W:0]       r2;
   logic [ACC_W:0]       diff;
   logic                 ge;
   logic [WORD_BITS-1:0] lim;
   logic [WORD_BITS-1:0] mag;

   assign mn  = num[ACC_W-1] ? (~num + 1'b1) : num;
   assign md  = den[ACC_W-1] ? (~den + 1'b1) : den;
   // quotient bits above the word are zero unless this top part reaches the divisor
   assign top = mn >> INT_BITS;

   assign r2     = {rem_ff, bits_ff[WORD_BITS-1]};
   assign diff   = r2 - {1'b0, md_ff};
   assign ge     = r2 >= {1'b0, md_ff};
   assign rem_in = ge ? diff[ACC_W-1:0] : r2[ACC_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            md_ff   <= md;
            rem_ff  <= top;
            bits_ff <= {mn[INT_BITS-1:0], {FRAC_BITS{1'b0}}};
            q_ff    <= '0;
            neg_ff  <= num[ACC_W-1] ^ den[ACC_W-1];
            over_ff <= top >= md;
         end else if (busy_ff) begin
            rem_ff  <= rem_in;
            bits_ff <= {bits_ff[WORD_BITS-2:0], 1'b0};
            q_ff    <= {q_ff[WORD_BITS-2:0], ge};
            cnt_ff  <= cnt_ff + 1'b1;
            if (cnt_ff == DCNT_W'(WORD_BITS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign lim  = neg_ff ? {1'b1, {(WORD_BITS-1){1'b0}}} : {1'b0, {(WORD_BITS-1){1'b1}}};
   assign clip = over_ff | (q_ff > lim);
   assign mag  = clip ? lim : q_ff;
   assign quo  = neg_ff ? (~mag + 1'b1) : mag;
   assign done = done_ff;

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import tts_pkg::*;

   localparam int STALL_LIMIT = 6000;
   localparam int HOLD_CYCLES = 900;
   localparam int DRAIN_WAIT  = 500;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   triangle_tangent_stream u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // held vertices of the current face, as the block should see them
   logic signed [WORD_BITS-1:0] prev_pos[3];
   logic signed [WORD_BITS-1:0] last_pos[3];
   logic signed [WORD_BITS-1:0] prev_tex[2];
   logic signed [WORD_BITS-1:0] last_tex[2];
   int unsigned face_held;

   rsp_type tangent_q[$];
   int      error_count;
   int      vertex_count;
   int      tangent_count;
   int      degenerate_count;
   int      clip_count;
   bit      quiet;
   bit      hold_request;
   int      idle_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic signed [WORD_BITS-1:0] clip_component(
      logic signed [127:0] num, logic signed [127:0] det, ref bit clipped);
      logic signed [127:0] quot;
      logic signed [127:0] lim_hi;
      logic signed [127:0] lim_lo;
      lim_hi = (128'sd1 <<< (WORD_BITS - 1)) - 128'sd1;
      lim_lo = -lim_hi - 128'sd1;
      quot = (num <<< FRAC_BITS) / det;
      if (quot > lim_hi) begin
         clipped = 1'b1;
         return lim_hi[WORD_BITS-1:0];
      end
      if (quot < lim_lo) begin
         clipped = 1'b1;
         return lim_lo[WORD_BITS-1:0];
      end
      return quot[WORD_BITS-1:0];
   endfunction

   task automatic predict_tangent(input req_type it);
      logic signed [127:0] du1, dv1, du2, dv2, det, e1, e2, num;
      logic signed [WORD_BITS-1:0] cur_pos[3];
      rsp_type exp_rsp;
      bit clipped;
      cur_pos[0] = it.pos_x;
      cur_pos[1] = it.pos_y;
      cur_pos[2] = it.pos_z;
      if (it.face_start) face_held = 0;
      if (face_held >= 2) begin
         du1 = 128'(last_tex[0]) - 128'(prev_tex[0]);
         dv1 = 128'(last_tex[1]) - 128'(prev_tex[1]);
         du2 = 128'(it.tex_u) - 128'(prev_tex[0]);
         dv2 = 128'(it.tex_v) - 128'(prev_tex[1]);
         det = du1 * dv2 - du2 * dv1;
         exp_rsp = '0;
         clipped = 1'b0;
         if (det == 0) begin
            exp_rsp.degenerate = 1'b1;
            degenerate_count++;
         end else begin
            for (int i = 0; i < 3; i++) begin
               e1 = 128'(last_pos[i]) - 128'(prev_pos[i]);
               e2 = 128'(cur_pos[i]) - 128'(prev_pos[i]);
               num = dv2 * e1 - dv1 * e2;
               case (i)
                  0: exp_rsp.tangent_x = clip_component(num, det, clipped);
                  1: exp_rsp.tangent_y = clip_component(num, det, clipped);
                  default: exp_rsp.tangent_z = clip_component(num, det, clipped);
               endcase
            end
            exp_rsp.saturated = clipped;
            if (clipped) clip_count++;
         end
         tangent_q = {tangent_q, exp_rsp};
      end
      for (int i = 0; i < 3; i++) begin
         prev_pos[i] = last_pos[i];
         last_pos[i] = cur_pos[i];
      end
      prev_tex[0] = last_tex[0];
      prev_tex[1] = last_tex[1];
      last_tex[0] = it.tex_u;
      last_tex[1] = it.tex_v;
      if (face_held < 2) face_held++;
   endtask

   // check each tangent and watch for a stuck handshake
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout with %0d tangents outstanding", tangent_q.size());
            $display("triangle_tangent_stream: mismatch");
            $finish;
         end
         if (rsp_valid && rsp_ready) begin
            if (tangent_q.size() == 0) begin
               $error("unexpected tangent %p", rsp_data);
               error_count++;
            end else begin
               exp_rsp = tangent_q.pop_front();
               tangent_count++;
               if (rsp_data.tangent_x !== exp_rsp.tangent_x) begin
                  $error("tangent_x expected %h actual %h", exp_rsp.tangent_x,
                         rsp_data.tangent_x);
                  error_count++;
               end
               if (rsp_data.tangent_y !== exp_rsp.tangent_y) begin
                  $error("tangent_y expected %h actual %h", exp_rsp.tangent_y,
                         rsp_data.tangent_y);
                  error_count++;
               end
               if (rsp_data.tangent_z !== exp_rsp.tangent_z) begin
                  $error("tangent_z expected %h actual %h", exp_rsp.tangent_z,
                         rsp_data.tangent_z);
                  error_count++;
               end
               if (rsp_data.degenerate !== exp_rsp.degenerate) begin
                  $error("degenerate expected %b actual %b", exp_rsp.degenerate,
                         rsp_data.degenerate);
                  error_count++;
               end
               if (rsp_data.saturated !== exp_rsp.saturated) begin
                  $error("saturated expected %b actual %b", exp_rsp.saturated,
                         rsp_data.saturated);
                  error_count++;
               end
            end
         end
      end
   end

   // result side: random stall bursts, plus one long hold-off on request
   initial begin
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready = 1'b0;
         end else if (quiet) begin
            rsp_ready = 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready = 1'b0;
         end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 14);
            rsp_ready = 1'b0;
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   task automatic send_vertex(input req_type it);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_data = it;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      predict_tangent(it);
      vertex_count++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (tangent_q.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   function automatic logic [WORD_BITS-1:0] pick_word();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return WORD_BITS'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
         2: return WORD_BITS'($signed($urandom_range(0, 16)) - 8) <<< FRAC_BITS;
         3: begin
            case ($urandom_range(0, 3))
               0: return {1'b0, {(WORD_BITS-1){1'b1}}};
               1: return {1'b1, {(WORD_BITS-1){1'b0}}};
               2: return '0;
               default: return '1;
            endcase
         end
         default: return WORD_BITS'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
      endcase
   endfunction

   function automatic req_type make_vertex(input int fs, input int px, input int py,
                                           input int pz, input int tu, input int tv);
      req_type it;
      it.pos_x = px;
      it.pos_y = py;
      it.pos_z = pz;
      it.tex_u = tu;
      it.tex_v = tv;
      it.face_start = fs[0];
      return it;
   endfunction

   task automatic test_directed();
      localparam int ONE = 1 << FRAC_BITS;
      localparam int MAXW = 32'h7fffffff;
      localparam int MINW = 32'h80000000;
      // vertices before any face start form one implicit face
      send_vertex(make_vertex(0, 0, 0, 0, 0, 0));
      send_vertex(make_vertex(0, ONE, 0, 0, ONE, 0));
      send_vertex(make_vertex(0, 0, ONE, 0, 0, ONE));
      send_vertex(make_vertex(0, ONE, ONE, ONE, ONE, ONE));
      // new face drops held vertices
      send_vertex(make_vertex(1, 2 * ONE, 0, -ONE, 0, 0));
      send_vertex(make_vertex(0, 0, 3 * ONE, 0, ONE, 0));
      send_vertex(make_vertex(0, ONE, 0, 5 * ONE, 0, ONE));
      // zero determinant: collinear texture coordinates
      send_vertex(make_vertex(1, ONE, 2, 3, ONE, ONE));
      send_vertex(make_vertex(0, 4, 5, 6, 2 * ONE, 2 * ONE));
      send_vertex(make_vertex(0, 7, 8, 9, 3 * ONE, 3 * ONE));
      // huge edges over a tiny UV area clip both ways
      send_vertex(make_vertex(1, MINW, MAXW, 0, 0, 0));
      send_vertex(make_vertex(0, MAXW, MINW, MINW, 1, 0));
      send_vertex(make_vertex(0, MINW, MAXW, MAXW, 0, 1));
      send_vertex(make_vertex(0, MAXW, MAXW, MINW, MINW, MAXW));
      // extreme texture coordinates
      send_vertex(make_vertex(1, MAXW, MINW, MAXW, MAXW, MINW));
      send_vertex(make_vertex(0, MINW, MINW, MINW, MINW, MAXW));
      send_vertex(make_vertex(0, -1, -1, -1, MAXW, MAXW));
      send_vertex(make_vertex(0, 0, 0, 0, -1, -1));
      // face start on every vertex gives nothing
      send_vertex(make_vertex(1, -1, 1, -1, 1, -1));
      send_vertex(make_vertex(1, 1, -1, 1, -1, 1));
      wait_drained();
   endtask

   task automatic test_random_faces(input int n_vertices);
      req_type it;
      int left;
      left = 0;
      for (int k = 0; k < n_vertices; k++) begin
         it.pos_x = pick_word();
         it.pos_y = pick_word();
         it.pos_z = pick_word();
         it.tex_u = pick_word();
         it.tex_v = pick_word();
         it.face_start = 1'b0;
         if (left == 0) begin
            // mostly well-formed faces; some short broken ones
            it.face_start = 1'b1;
            left = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 10);
         end else if ($urandom_range(0, 7) == 0) begin
            // repeat the last texcoord to force a zero determinant
            it.tex_u = last_tex[0];
            it.tex_v = last_tex[1];
         end
         left--;
         send_vertex(it);
      end
   endtask

   task automatic test_backpressure();
      hold_request = 1'b1;
      test_random_faces(40);
      wait_drained();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      quiet = 1'b0;
      hold_request = 1'b0;
      error_count = 0;
      vertex_count = 0;
      tangent_count = 0;
      degenerate_count = 0;
      clip_count = 0;
      idle_cycles = 0;
      face_held = 0;
      for (int i = 0; i < 3; i++) begin
         prev_pos[i] = '0;
         last_pos[i] = '0;
      end
      for (int i = 0; i < 2; i++) begin
         prev_tex[i] = '0;
         last_tex[i] = '0;
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random_faces(600);
      test_backpressure();
      test_random_faces(500);
      quiet = 1'b1;
      test_random_faces(100);
      wait_drained();

      $display("sent %0d vertices, checked %0d tangents", vertex_count, tangent_count);
      $display("%0d zero-determinant and %0d clipped triangles", degenerate_count,
               clip_count);
      if (error_count == 0 && tangent_q.size() == 0) begin
         $display("triangle_tangent_stream: match");
      end else begin
         $display("triangle_tangent_stream: mismatch");
      end
      $finish;
   end

endmodule
